// ----- src/jts_pkg.sv -----
// Shared types and byte codes for the JIS to Shift_JIS stream converter.
// No dependencies.
`timescale 1ns / 1ps

package jts_pkg;

    localparam int MAX_RESULTS = 5;
    localparam int CNT_W       = 3;

    localparam logic [7:0] ESC_BYTE    = 8'h1b;
    localparam logic [7:0] DOLLAR_BYTE = 8'h24;
    localparam logic [7:0] PAREN_BYTE  = 8'h28;
    localparam logic [7:0] FINAL_B     = 8'h42;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_EOL  = 1'b1;

    typedef struct packed {
        logic [7:0] data;
        logic       kind;
        logic       odd;
    } result_t;

    // up to five results caused by one request, in order
    typedef struct packed {
        result_t [MAX_RESULTS-1:0] r;
        logic [CNT_W-1:0]          cnt;
    } bundle_t;

endpackage

// ----- src/jts_core.sv -----
// Conversion core: mode and escape state registers plus the logic that maps
// one byte onto its list of results. Depends on jts_pkg.
`timescale 1ns / 1ps

module jts_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  logic [7:0]      in_byte,
    input  logic            end_of_line,
    output jts_pkg::bundle_t bundle
);
    import jts_pkg::*;

    logic       kanji_mode_reg, kanji_mode_next;
    logic [1:0] held_count_reg, held_count_next;
    logic [7:0] held_second_reg, held_second_next;
    logic       pair_pending_reg, pair_pending_next;
    logic [7:0] pair_first_reg, pair_first_next;

    function automatic bundle_t put(bundle_t b, logic [7:0] v, logic k, logic o);
        bundle_t t;
        t = b;
        if (t.cnt < CNT_W'(MAX_RESULTS))
        begin
            t.r[t.cnt].data = v;
            t.r[t.cnt].kind = k;
            t.r[t.cnt].odd  = o;
            t.cnt           = t.cnt + CNT_W'(1);
        end
        return t;
    endfunction

    // JIS row/cell to Shift_JIS lead/trail, 8-bit wrap throughout
    function automatic bundle_t put_pair(bundle_t b, logic [7:0] c1, logic [7:0] c2);
        logic [7:0] lead;
        logic [7:0] trail;
        bundle_t    t;
        if (c1[0])
        begin
            lead  = {1'b0, c1[7:1]} + 8'h71;
            trail = c2 + 8'h1f;
            if (trail >= 8'h7f)
            begin
                trail = trail + 8'h01;
            end
        end
        else
        begin
            lead  = {1'b0, c1[7:1]} + 8'h70;
            trail = c2 + 8'h7e;
        end
        if (lead >= 8'ha0)
        begin
            lead = lead + 8'h40;
        end
        t = put(b, lead, KIND_DATA, 1'b0);
        t = put(t, trail, KIND_DATA, 1'b0);
        return t;
    endfunction

    always_comb
    begin
        logic    fresh;
        logic    odd;
        bundle_t bun;
        bun               = '0;
        fresh             = 1'b0;
        odd               = 1'b0;
        kanji_mode_next   = kanji_mode_reg;
        held_count_next   = held_count_reg;
        held_second_next  = held_second_reg;
        pair_pending_next = pair_pending_reg;
        pair_first_next   = pair_first_reg;

        case (held_count_reg)
            2'd0:
            begin
                fresh = 1'b1;
            end
            2'd1:
            begin
                if (in_byte == DOLLAR_BYTE || in_byte == PAREN_BYTE)
                begin
                    held_second_next = in_byte;
                    held_count_next  = 2'd2;
                end
                else
                begin
                    held_count_next = 2'd0;
                    if (kanji_mode_reg)
                    begin
                        bun = put_pair(bun, ESC_BYTE, in_byte);
                    end
                    else
                    begin
                        bun   = put(bun, ESC_BYTE, KIND_DATA, 1'b0);
                        fresh = 1'b1;
                    end
                end
            end
            default:
            begin
                held_count_next = 2'd0;
                if (in_byte == FINAL_B)
                begin
                    kanji_mode_next = (held_second_reg == DOLLAR_BYTE);
                end
                else
                begin
                    if (kanji_mode_reg)
                    begin
                        bun = put_pair(bun, ESC_BYTE, held_second_reg);
                    end
                    else
                    begin
                        bun = put(bun, ESC_BYTE, KIND_DATA, 1'b0);
                        bun = put(bun, held_second_reg, KIND_DATA, 1'b0);
                    end
                    fresh = 1'b1;
                end
            end
        endcase

        // mode cannot change on a path that reaches here
        if (fresh)
        begin
            if (kanji_mode_reg && pair_pending_reg)
            begin
                pair_pending_next = 1'b0;
                bun = put_pair(bun, pair_first_reg, in_byte);
            end
            else if (in_byte == ESC_BYTE)
            begin
                held_count_next = 2'd1;
            end
            else if (kanji_mode_reg)
            begin
                pair_first_next   = in_byte;
                pair_pending_next = 1'b1;
            end
            else
            begin
                bun = put(bun, in_byte, KIND_DATA, 1'b0);
            end
        end

        if (end_of_line)
        begin
            if (held_count_next == 2'd1)
            begin
                if (kanji_mode_next)
                begin
                    odd = 1'b1;
                end
                else
                begin
                    bun = put(bun, ESC_BYTE, KIND_DATA, 1'b0);
                end
            end
            else if (held_count_next == 2'd2)
            begin
                if (kanji_mode_next)
                begin
                    bun = put_pair(bun, ESC_BYTE, held_second_next);
                end
                else
                begin
                    bun = put(bun, ESC_BYTE, KIND_DATA, 1'b0);
                    bun = put(bun, held_second_next, KIND_DATA, 1'b0);
                end
            end
            if (pair_pending_next)
            begin
                odd = 1'b1;
            end
            held_count_next   = 2'd0;
            held_second_next  = 8'h00;
            pair_pending_next = 1'b0;
            pair_first_next   = 8'h00;
            bun = put(bun, 8'h00, KIND_EOL, odd);
        end
        bundle = bun;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kanji_mode_reg   <= 1'b0;
            held_count_reg   <= 2'd0;
            held_second_reg  <= 8'h00;
            pair_pending_reg <= 1'b0;
            pair_first_reg   <= 8'h00;
        end
        else if (step)
        begin
            kanji_mode_reg   <= kanji_mode_next;
            held_count_reg   <= held_count_next;
            held_second_reg  <= held_second_next;
            pair_pending_reg <= pair_pending_next;
            pair_first_reg   <= pair_first_next;
        end
    end

endmodule

// ----- src/jts_burst.sv -----
// Result buffer: holds the results of one request and hands them out one a
// cycle on the output handshake while out_ready is high. Depends on jts_pkg.
`timescale 1ns / 1ps

module jts_burst (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  jts_pkg::bundle_t bundle,
    output logic             free,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       out_byte,
    output logic             kind,
    output logic             odd_dropped
);
    import jts_pkg::*;

    result_t [MAX_RESULTS-1:0] entry_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic [CNT_W-1:0]          idx_reg;
    logic                      last;
    result_t                   cur;

    assign out_valid = (idx_reg != cnt_reg);
    assign last      = (idx_reg == cnt_reg - CNT_W'(1));
    // free when empty, or when the final result leaves this cycle
    assign free      = !out_valid || (out_ready && last);

    assign cur         = entry_reg[idx_reg];
    assign out_byte    = cur.data;
    assign kind        = cur.kind;
    assign odd_dropped = cur.odd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else if (load)
        begin
            cnt_reg <= bundle.cnt;
            idx_reg <= '0;
        end
        else if (out_valid && out_ready)
        begin
            idx_reg <= idx_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            entry_reg <= bundle.r;
        end
    end

endmodule

// ----- src/jts_top_note.sv -----
// Input holding register between the input handshake and the conversion
// core. Depends on nothing.
`timescale 1ns / 1ps

module jts_inreg (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       end_of_line,
    input  logic       take,
    output logic       held_valid,
    output logic [7:0] held_byte,
    output logic       held_eol
);
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       eol_reg;

    assign in_ready   = !valid_reg || take;
    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;
    assign held_eol   = eol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= in_byte;
            eol_reg  <= end_of_line;
        end
    end

endmodule

// ----- src/jis_to_shift_jis_stream.sv -----
// Top level of the JIS (ISO-2022-JP) to Shift_JIS stream converter.
// Depends on jts_pkg, jts_inreg, jts_core and jts_burst.
`timescale 1ns / 1ps

// Converts a JIS byte stream to Shift_JIS, one input byte per request, with
// ESC $ B / ESC ( B switching a kanji/ASCII mode that persists across lines.
// Each request gives zero to five results; a request flagged end_of_line
// closes with an end marker (kind = 1, odd_dropped set if a lone kanji byte
// was discarded). A request is registered in the input holding register,
// converted combinationally and its results are loaded into the output
// buffer. The single output port sets the rate: a new request is taken only
// when the buffer is empty or when its final result leaves, so the results
// of one request are all handed out before those of the next.

module jis_to_shift_jis_stream (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       end_of_line,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       kind,
    output logic       odd_dropped
);
    import jts_pkg::*;

    logic       held_valid;
    logic [7:0] held_byte;
    logic       held_eol;
    logic       free;
    logic       take;
    bundle_t    bundle;

    assign take = held_valid && free;

    jts_inreg u_inreg (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .end_of_line (end_of_line),
        .take        (take),
        .held_valid  (held_valid),
        .held_byte   (held_byte),
        .held_eol    (held_eol)
    );

    jts_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (take),
        .in_byte     (held_byte),
        .end_of_line (held_eol),
        .bundle      (bundle)
    );

    jts_burst u_burst (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (take),
        .bundle      (bundle),
        .free        (free),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .kind        (kind),
        .odd_dropped (odd_dropped)
    );

endmodule

// ----- src/jts_checker.sv -----
// Port-level checks for the converter, bound onto the top level.
// Depends on jis_to_shift_jis_stream.
`timescale 1ns / 1ps

module jts_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       kind,
    input logic       odd_dropped
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_byte) && $stable(kind)
            && $stable(odd_dropped))
        else $error("output payload changed while stalled");

    // input back-pressure only while the output side is busy
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with nothing to deliver");

    a_odd_on_marker: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !kind |-> !odd_dropped)
        else $error("odd flag on a data byte");

    a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind |-> out_byte == 8'h00)
        else $error("end marker carries data");

endmodule

bind jis_to_shift_jis_stream jts_checker u_jts_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .kind        (kind),
    .odd_dropped (odd_dropped)
);
